// ----- hw/rtl/b85_pkg.sv -----
// Shared types, constants and the digit-to-character map for the base-85 encoder.
// No dependencies; every other file of the block but the checker imports this package.
package b85_pkg;

  localparam int unsigned GROUP_DIGITS = 5;
  localparam int unsigned DIGIT_W      = 7;
  localparam int unsigned COUNT_W      = 3;
  localparam int unsigned FIFO_DEPTH   = 2;
  localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);

  localparam logic [7:0]  DIGIT_BASE = 8'd85;
  // floor(2^32 / 85); the product estimate is low by at most one
  localparam logic [25:0] RECIP_85   = 26'd50529027;

  typedef struct packed {
    logic [31:0]        value;
    logic [COUNT_W-1:0] count;
    logic               fin;
  } job_t;

  typedef struct packed {
    logic [GROUP_DIGITS-1:0][DIGIT_W-1:0] digits;
    logic [COUNT_W-1:0]                   count;
    logic                                 fin;
  } group_t;

  function automatic logic [6:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [6:0] c;
    c = 7'h7E;
    if (d < 7'd10) begin
      c = d + 7'd48;
    end else if (d < 7'd36) begin
      c = d + 7'd55;
    end else if (d < 7'd62) begin
      c = d + 7'd61;
    end else begin
      case (d)
        7'd62:   c = 7'h21;
        7'd63:   c = 7'h23;
        7'd64:   c = 7'h24;
        7'd65:   c = 7'h25;
        7'd66:   c = 7'h26;
        7'd67:   c = 7'h28;
        7'd68:   c = 7'h29;
        7'd69:   c = 7'h2A;
        7'd70:   c = 7'h2B;
        7'd71:   c = 7'h2D;
        7'd72:   c = 7'h3B;
        7'd73:   c = 7'h3C;
        7'd74:   c = 7'h3D;
        7'd75:   c = 7'h3E;
        7'd76:   c = 7'h3F;
        7'd77:   c = 7'h40;
        7'd78:   c = 7'h5E;
        7'd79:   c = 7'h5F;
        7'd80:   c = 7'h60;
        7'd81:   c = 7'h7B;
        7'd82:   c = 7'h7C;
        7'd83:   c = 7'h7D;
        default: c = 7'h7E;
      endcase
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/base85_stream_encoder.sv -----
// Base-85 stream encoder, top level: front end, job queue, converter, emitter.
// Bytes enter the queue at one byte per cycle while full is low. The group rate is set by
// the shared divide-by-85 unit: four divisions per group, each a multiply and a fix step.
// The converter finishes one group before it takes the next job from the queue.
// Output: one character per cycle while pop is held and a converted group is waiting.
// Synchronous active-low reset clears the group, the queue and all valid state.
// Depends on b85_pkg and the b85_* modules.
module base85_stream_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_code_char,
  output logic       out_last_of_run,
  output logic       out_end_of_output
);
  import b85_pkg::*;

  job_t   fr_job, q_job;
  logic   fr_push, q_full, q_empty, q_pop;
  group_t grp;
  logic   grp_valid, grp_take;

  b85_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .job_push          (fr_push),
    .job_full          (q_full),
    .job               (fr_job)
  );

  b85_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fr_push),
    .wr_data (fr_job),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_job),
    .empty   (q_empty)
  );

  b85_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (q_empty),
    .job       (q_job),
    .job_pop   (q_pop),
    .grp_valid (grp_valid),
    .grp_take  (grp_take),
    .grp       (grp)
  );

  b85_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .grp_valid         (grp_valid),
    .grp               (grp),
    .grp_take          (grp_take),
    .empty             (empty),
    .pop               (pop),
    .out_code_char     (out_code_char),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_output (out_end_of_output)
  );

endmodule

// ----- hw/rtl/b85_front.sv -----
// Front end: accepts bytes, packs them big-endian into groups, pads a final
// partial group and issues one conversion job per group. Depends on b85_pkg.
module b85_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    in_data_byte,
  input  logic          in_end_of_message,
  output logic          job_push,
  input  logic          job_full,
  output b85_pkg::job_t job
);
  import b85_pkg::*;

  logic [23:0] group_r, group_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        accept;

  assign full   = job_full;
  assign accept = push && !job_full;

  always_comb begin
    job.fin   = in_end_of_message;
    job.count = {1'b0, cnt_r} + 3'd2;
    case (cnt_r)
      2'd0:    job.value = {in_data_byte, 24'd0};
      2'd1:    job.value = {group_r[7:0], in_data_byte, 16'd0};
      2'd2:    job.value = {group_r[15:0], in_data_byte, 8'd0};
      default: job.value = {group_r, in_data_byte};
    endcase
  end

  assign job_push = accept && ((cnt_r == 2'd3) || in_end_of_message);

  always_comb begin
    group_nxt = group_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      if (job_push) begin
        group_nxt = 24'd0;
        cnt_nxt   = 2'd0;
      end else begin
        group_nxt = {group_r[15:0], in_data_byte};
        cnt_nxt   = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= 24'd0;
      cnt_r   <= 2'd0;
    end else begin
      group_r <= group_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/b85_fifo.sv -----
// Short job queue between the front end and the converter.
// Depends on b85_pkg for the job type and depth.
module b85_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  b85_pkg::job_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output b85_pkg::job_t rd_data,
  output logic          empty
);
  import b85_pkg::*;

  job_t                  slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_PTR_W:0]   cnt_r, cnt_nxt;
  logic                  do_wr, do_rd;

  assign full    = (cnt_r == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/b85_conv.sv -----
// Converter: splits a 32-bit group into five base-85 digits with a shared
// divide-by-85 unit (reciprocal multiply step, then one correction step).
// Depends on b85_pkg.
module b85_conv (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_empty,
  input  b85_pkg::job_t   job,
  output logic            job_pop,
  output logic            grp_valid,
  input  logic            grp_take,
  output b85_pkg::group_t grp
);
  import b85_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]  st_r, st_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [31:0] val_r, val_nxt;
  logic [57:0] prod_r, prod_nxt;
  logic [GROUP_DIGITS-1:0][DIGIT_W-1:0] dig_r, dig_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic        fin_r, fin_nxt;

  logic [25:0] q_est;
  logic [31:0] qx85;
  logic [31:0] rem_w;
  logic [7:0]  rem8;
  logic        ge;
  logic [31:0] q_fix;
  logic [DIGIT_W-1:0] digit;
  logic [2:0]  widx;

  assign q_est = prod_r[57:32];
  assign qx85  = {6'd0, q_est} * 32'(DIGIT_BASE);
  assign rem_w = val_r - qx85;
  assign rem8  = rem_w[7:0];
  assign ge    = (rem8 >= DIGIT_BASE);
  assign q_fix = {6'd0, q_est} + {31'd0, ge};
  assign digit = ge ? DIGIT_W'(rem8 - DIGIT_BASE) : rem8[DIGIT_W-1:0];
  assign widx  = 3'd4 - {1'b0, step_r};

  assign grp_valid  = (st_r == ST_DONE);
  assign grp.digits = dig_r;
  assign grp.count  = cnt_r;
  assign grp.fin    = fin_r;

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    val_nxt  = val_r;
    prod_nxt = prod_r;
    dig_nxt  = dig_r;
    cnt_nxt  = cnt_r;
    fin_nxt  = fin_r;
    job_pop  = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!job_empty) begin
          job_pop = 1'b1;
        end
      end
      ST_MUL: begin
        prod_nxt = 58'(val_r) * 58'(RECIP_85);
        st_nxt   = ST_FIX;
      end
      ST_FIX: begin
        val_nxt       = q_fix;
        dig_nxt[widx] = digit;
        if (step_r == 2'd3) begin
          dig_nxt[0] = q_fix[DIGIT_W-1:0];
          st_nxt     = ST_DONE;
        end else begin
          step_nxt = step_r + 2'd1;
          st_nxt   = ST_MUL;
        end
      end
      ST_DONE: begin
        if (grp_take) begin
          if (!job_empty) begin
            job_pop = 1'b1;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (job_pop) begin
      val_nxt  = job.value;
      cnt_nxt  = job.count;
      fin_nxt  = job.fin;
      step_nxt = 2'd0;
      st_nxt   = ST_MUL;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    prod_r <= prod_nxt;
    dig_r  <= dig_nxt;
    cnt_r  <= cnt_nxt;
    fin_r  <= fin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      step_r <= 2'd0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

// ----- hw/rtl/b85_emit.sv -----
// Back end: holds one converted group and streams its characters, most
// significant first, through an output register. Depends on b85_pkg.
module b85_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            grp_valid,
  input  b85_pkg::group_t grp,
  output logic            grp_take,
  output logic            empty,
  input  logic            pop,
  output logic [6:0]      out_code_char,
  output logic            out_last_of_run,
  output logic            out_end_of_output
);
  import b85_pkg::*;

  logic [GROUP_DIGITS-1:0][DIGIT_W-1:0] edig_r, edig_nxt;
  logic [COUNT_W-1:0] ecnt_r, ecnt_nxt;
  logic               efin_r, efin_nxt;
  logic [2:0]         eidx_r, eidx_nxt;
  logic               ebuf_v_r, ebuf_v_nxt;
  logic               out_v_r, out_v_nxt;
  logic [6:0]         char_r, char_nxt;
  logic               last_r, last_nxt;
  logic               eoo_r, eoo_nxt;
  logic               load, is_last;

  assign is_last  = (eidx_r == (ecnt_r - 3'd1));
  assign load     = ebuf_v_r && (!out_v_r || pop);
  assign grp_take = grp_valid && (!ebuf_v_r || (load && is_last));

  assign empty             = !out_v_r;
  assign out_code_char     = char_r;
  assign out_last_of_run   = last_r;
  assign out_end_of_output = eoo_r;

  always_comb begin
    edig_nxt   = edig_r;
    ecnt_nxt   = ecnt_r;
    efin_nxt   = efin_r;
    eidx_nxt   = eidx_r;
    ebuf_v_nxt = ebuf_v_r;
    out_v_nxt  = out_v_r;
    char_nxt   = char_r;
    last_nxt   = last_r;
    eoo_nxt    = eoo_r;
    if (pop) begin
      out_v_nxt = 1'b0;
    end
    if (load) begin
      out_v_nxt = 1'b1;
      char_nxt  = digit_char(edig_r[eidx_r]);
      last_nxt  = is_last;
      eoo_nxt   = is_last && efin_r;
      if (is_last) begin
        ebuf_v_nxt = 1'b0;
      end else begin
        eidx_nxt = eidx_r + 3'd1;
      end
    end
    if (grp_take) begin
      edig_nxt   = grp.digits;
      ecnt_nxt   = grp.count;
      efin_nxt   = grp.fin;
      eidx_nxt   = 3'd0;
      ebuf_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    edig_r <= edig_nxt;
    ecnt_r <= ecnt_nxt;
    efin_r <= efin_nxt;
    eidx_r <= eidx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    eoo_r  <= eoo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ebuf_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      ebuf_v_r <= ebuf_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

endmodule

// ----- hw/rtl/b85_checker.sv -----
// Port-level checks for the base-85 encoder, attached to the top level by bind.
// Sees only the top-level ports; no package dependency.
module b85_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic [7:0] in_data_byte,
  input logic       in_end_of_message,
  input logic       empty,
  input logic       pop,
  input logic [6:0] out_code_char,
  input logic       out_last_of_run,
  input logic       out_end_of_output
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not cleared by reset");

  a_input_known: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full |-> !$isunknown({in_data_byte, in_end_of_message}))
    else $error("accepted transaction carries unknown bits");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_code_char) && $stable(out_end_of_output))
    else $error("stalled result changed");

  a_eoo_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_end_of_output |-> out_last_of_run)
    else $error("end of output without end of run");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_code_char >= 7'd33 && out_code_char <= 7'd126 &&
               out_code_char != 7'd34 && out_code_char != 7'd39 &&
               out_code_char != 7'd44 && out_code_char != 7'd46)
    else $error("character outside the alphabet");

endmodule

bind base85_stream_encoder b85_checker u_b85_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .push              (push),
  .full              (full),
  .in_data_byte      (in_data_byte),
  .in_end_of_message (in_end_of_message),
  .empty             (empty),
  .pop               (pop),
  .out_code_char     (out_code_char),
  .out_last_of_run   (out_last_of_run),
  .out_end_of_output (out_end_of_output)
);
